[hdl/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths and the reset modulus for the modular exponentiation block
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    localparam int DEF_EXP_BITS = 32;
    localparam int DEF_MOD_BITS = 31;

    // fixed field widths of the ports
    localparam int BASE_W = 31;
    localparam int RES_W  = 31;
    localparam int CFG_W  = 31;

    localparam logic [CFG_W-1:0] RESET_MODULUS = 31'd998244353;

endpackage

`default_nettype wire

[hdl/mexp_if.sv]
// ----------------------------------------------------------------------------
// mexp_op_if / mexp_res_if
// valid/ready channels for operand words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_op_if #(
    parameter int EXP_BITS = mexp_pkg::DEF_EXP_BITS
);
    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::BASE_W-1:0] base_value;
    logic [EXP_BITS-1:0]         exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_res_if;
    logic                       valid;
    logic                       ready;
    logic [mexp_pkg::RES_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

`default_nettype wire

[hdl/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// After acceptance the base is reduced, then each exponent bit gives a
// multiply when it is set and always a square; a modulus below two gives
// 0 and an exponent of zero gives 1. All modular products go through one
// shift-add multiplier that handles one multiplier bit per cycle, reducing
// as it goes, and the base is first reduced on the same unit. The block
// takes a new operand word only when idle, but a finished result may still
// wait in the output register while the next word is accepted. The modulus
// is written through i_cfg_we and i_cfg_wdata, keeping its low MOD_BITS
// bits; the user must write it only while no operation is in progress,
// which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
    parameter int EXP_BITS = mexp_pkg::DEF_EXP_BITS,
    parameter int MOD_BITS = mexp_pkg::DEF_MOD_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [mexp_pkg::CFG_W-1:0] i_cfg_wdata,
    mexp_op_if.sink                         i_op,
    mexp_res_if.source                      o_res
);

    localparam int BW  = mexp_pkg::BASE_W;
    localparam int RW  = mexp_pkg::RES_W;
    localparam int CW  = $clog2(BW);
    localparam int ECW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam int TW  = MOD_BITS + 2;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_NEXT, S_FIN} t_state;
    typedef enum logic [1:0] {OP_RED, OP_MUL, OP_SQR} t_op;

    t_state              r_state;
    t_op                 r_op;
    logic [MOD_BITS-1:0] r_mod;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_sq;
    logic [EXP_BITS-1:0] r_exp;
    logic [ECW-1:0]      r_ecnt;
    logic [MOD_BITS-1:0] r_mm_a;
    logic [BW-1:0]       r_mm_b;
    logic [MOD_BITS-1:0] r_mm_r;
    logic [CW-1:0]       r_mm_cnt;
    logic                r_out_valid;
    logic [RW-1:0]       r_res;

    logic [CW-1:0]       mm_last;
    logic [TW-1:0]       mm_t;
    logic [TW-1:0]       mm_m1;
    logic [TW-1:0]       mm_m2;
    logic [MOD_BITS-1:0] n_mm_r;
    logic [BW-1:0]       sq_aligned;

    // shared multiplier step: r = (2r + bit*a) mod m, with 2r + a below 3m
    always_comb begin
        mm_m1  = {2'b00, r_mod};
        mm_m2  = {1'b0, r_mod, 1'b0};
        mm_t   = {1'b0, r_mm_r, 1'b0} + (r_mm_b[BW-1] ? {2'b00, r_mm_a} : '0);
        n_mm_r = r_mm_r;
        priority if (mm_t >= mm_m2) begin
            n_mm_r = MOD_BITS'(mm_t - mm_m2);
        end else if (mm_t >= mm_m1) begin
            n_mm_r = MOD_BITS'(mm_t - mm_m1);
        end else begin
            n_mm_r = MOD_BITS'(mm_t);
        end
    end

    assign mm_last    = (r_op == OP_RED) ? CW'(BW - 1) : CW'(MOD_BITS - 1);
    assign sq_aligned = BW'(r_sq) << (BW - MOD_BITS);

    assign i_op.ready         = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.power_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mod       <= mexp_pkg::RESET_MODULUS[MOD_BITS-1:0];
        end else begin
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata[MOD_BITS-1:0];
            end
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_op.valid) begin
                        r_exp  <= i_op.exponent;
                        r_ecnt <= '0;
                        if (r_mod < MOD_BITS'(2)) begin
                            r_acc   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            // reduce the base first as 1 * base mod m
                            r_acc    <= MOD_BITS'(1);
                            r_op     <= OP_RED;
                            r_mm_a   <= MOD_BITS'(1);
                            r_mm_b   <= i_op.base_value;
                            r_mm_r   <= '0;
                            r_mm_cnt <= '0;
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_mm_r   <= n_mm_r;
                    r_mm_b   <= r_mm_b << 1;
                    r_mm_cnt <= r_mm_cnt + CW'(1);
                    if (r_mm_cnt == mm_last) begin
                        r_mm_r   <= '0;
                        r_mm_cnt <= '0;
                        unique case (r_op)
                            OP_RED: begin
                                r_sq    <= n_mm_r;
                                r_state <= S_NEXT;
                            end
                            OP_MUL: begin
                                r_acc  <= n_mm_r;
                                r_op   <= OP_SQR;
                                r_mm_a <= r_sq;
                                r_mm_b <= sq_aligned;
                            end
                            OP_SQR: begin
                                r_sq <= n_mm_r;
                                if (r_ecnt == ECW'(EXP_BITS - 1)) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_ecnt  <= r_ecnt + ECW'(1);
                                    r_exp   <= r_exp >> 1;
                                    r_state <= S_NEXT;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_NEXT: begin
                    r_mm_b  <= sq_aligned;
                    r_state <= S_MUL;
                    if (r_exp[0]) begin
                        r_op   <= OP_MUL;
                        r_mm_a <= r_acc;
                    end else begin
                        r_op   <= OP_SQR;
                        r_mm_a <= r_sq;
                    end
                end
                S_FIN: begin
                    // wait for the previous word to leave the output register
                    if (!r_out_valid || o_res.ready) begin
                        r_res       <= RW'(r_acc);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_partial_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_mm_r < r_mod))
        else $error("partial product not reduced below modulus");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (r_mod >= MOD_BITS'(2))) |-> (o_res.power_result < RW'(r_mod)))
        else $error("result not below modulus");

    a_small_mod_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (r_mod < MOD_BITS'(2))) |-> (o_res.power_result == '0))
        else $error("modulus below two must give zero");

    a_ecnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> (r_ecnt <= ECW'(EXP_BITS - 1)))
        else $error("exponent bit counter out of range");

    a_accept_loads_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.valid && i_op.ready && (r_mod >= MOD_BITS'(2)))
            |=> (r_state == S_MUL && r_op == OP_RED && r_mm_cnt == '0))
        else $error("accepted word did not start base reduction");

endmodule

`default_nettype wire
